// ===== hw/rtl/box_blur_3x3_edge_clipped_core_defines.svh =====
// ----------------------------------------------------------------------------
// Box blur core assertion macros
// Shared assertion forms for the box blur checker.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_EDGE_CLIPPED_CORE_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_CLIPPED_CORE_DEFINES_SVH

// checked only out of reset
`define BB3_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked in and out of reset
`define BB3_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/bb3_pkg.sv =====
// ----------------------------------------------------------------------------
// Box blur package
// Pixel type, register indexes and rounding constants.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int CH_W  = 8;
    localparam int PX_W  = 3 * CH_W;
    localparam int SUM_W = 12;      // nine 8-bit samples
    localparam int CFG_W = 11;
    localparam int IDX_W = 1;
    localparam int COORD_W = 10;

    typedef logic [PX_W-1:0]  t_px;
    typedef logic [SUM_W-1:0] t_sum;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;

    // neighbour count: corner, edge, interior
    typedef enum logic [1:0] {
        CNT4,
        CNT6,
        CNT9
    } t_cnt;

    // x/6 = (x*RECIP6)>>SHIFT6 for x < 21845; x/18 likewise for x < 116508
    localparam logic [15:0] RECIP6  = 16'd43691;
    localparam int          SHIFT6  = 18;
    localparam logic [17:0] RECIP18 = 18'd233017;
    localparam int          SHIFT18 = 22;

endpackage

// ===== hw/rtl/box_blur_3x3_edge_clipped_core.sv =====
// ----------------------------------------------------------------------------
// 3x3 box blur core, edge clipped
// Blurs a raster-order RGB stream with a 3x3 mean over in-frame neighbours.
// ----------------------------------------------------------------------------
// One pixel beat is taken per clock unless the core stalls. A pixel that
// produces k results (up to four on the last row and column) holds the
// input until its last result is issued, since the result sequencer emits
// one result per clock unless the output stalls. Pixels in row 0 or column 0
// produce nothing. A pixel beat's first result passes four registers on the
// way: line store read, window/sequencer, neighbour sum, rounding divide.
// The line store is one memory of MAX_WIDTH entries holding the two previous
// rows per column, written once per pixel. Writing a size register
// restarts the frame; sizes are clamped to 2..MAX_WIDTH / MAX_HEIGHT.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_clipped_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bb3_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [bb3_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [bb3_pkg::CH_W-1:0]     i_in_red,
    input  logic [bb3_pkg::CH_W-1:0]     i_in_green,
    input  logic [bb3_pkg::CH_W-1:0]     i_in_blue,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [bb3_pkg::COORD_W-1:0]  o_out_row,
    output logic [bb3_pkg::COORD_W-1:0]  o_out_col,
    output logic [bb3_pkg::CH_W-1:0]     o_out_red,
    output logic [bb3_pkg::CH_W-1:0]     o_out_green,
    output logic [bb3_pkg::CH_W-1:0]     o_out_blue,
    output logic                         o_run_last
);

    localparam int CW = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;

    // ---------------- configuration and counters ----------------
    logic [bb3_pkg::CFG_W-1:0] r_fw, r_fh;
    logic [CW-1:0]             r_col;
    logic [RW-1:0]             r_row;
    logic [CW:0]               w_eff;
    logic [RW:0]               h_eff;
    logic                      in_acc, cur_lc, cur_lr;

    always_comb begin
        if (32'(r_fw) > 32'(MAX_WIDTH))  w_eff = (CW+1)'(MAX_WIDTH);
        else if (r_fw < 11'd2)           w_eff = (CW+1)'(2);
        else                             w_eff = (CW+1)'(r_fw);
        if (32'(r_fh) > 32'(MAX_HEIGHT)) h_eff = (RW+1)'(MAX_HEIGHT);
        else if (r_fh < 11'd2)           h_eff = (RW+1)'(2);
        else                             h_eff = (RW+1)'(r_fh);
    end

    assign cur_lc = ({1'b0, r_col} == w_eff - (CW+1)'(1));
    assign cur_lr = ({1'b0, r_row} == h_eff - (RW+1)'(1));
    assign in_acc = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw  <= bb3_pkg::WIDTH_RST;
            r_fh  <= bb3_pkg::HEIGHT_RST;
            r_col <= '0;
            r_row <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bb3_pkg::REG_FRAME_WIDTH:  r_fw <= i_cfg_data;
                bb3_pkg::REG_FRAME_HEIGHT: r_fh <= i_cfg_data;
                default: ;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (cur_lc) begin
                r_col <= '0;
                r_row <= cur_lr ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // ---------------- stage 1: line store read ----------------
    logic                 r_p1_v, r_p1_lc, r_p1_lr, r_p1_emit, r_p1_top, r_p1_left;
    bb3_pkg::t_px         r_p1_px;
    logic [CW-1:0]        r_p1_j;
    logic [RW-1:0]        r_p1_i;
    logic                 p1_adv, job_ready;
    logic [CW-1:0]        rd_addr;
    logic [2*bb3_pkg::PX_W-1:0] r_line [MAX_WIDTH];
    logic [2*bb3_pkg::PX_W-1:0] r_rdata;
    bb3_pkg::t_px         top_px, mid_px;

    assign p1_adv     = r_p1_v & (!r_p1_emit | job_ready);
    assign o_in_ready = !r_p1_v | p1_adv;
    // a stalled beat re-reads its own entry so the read data stays current
    assign rd_addr    = (r_p1_v & !p1_adv) ? r_p1_j : r_col;
    assign top_px     = r_rdata[2*bb3_pkg::PX_W-1:bb3_pkg::PX_W];
    assign mid_px     = r_rdata[bb3_pkg::PX_W-1:0];

    always_ff @(posedge i_clk) begin
        r_rdata <= r_line[rd_addr];
        if (p1_adv) r_line[r_p1_j] <= {mid_px, r_p1_px};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p1_v <= 1'b0;
        else if (in_acc) r_p1_v <= 1'b1;
        else if (p1_adv) r_p1_v <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p1_px   <= {i_in_blue, i_in_green, i_in_red};
            r_p1_j    <= r_col;
            r_p1_i    <= r_row;
            r_p1_lc   <= cur_lc;
            r_p1_lr   <= cur_lr;
            r_p1_emit <= (r_row != '0) && (r_col != '0);
            r_p1_top  <= (r_row > RW'(1));
            r_p1_left <= (r_col > CW'(1));
        end
    end

    // ---------------- window and result sequencer ----------------
    bb3_pkg::t_px r_win [3][2];
    bb3_pkg::t_px col2 [3];
    bb3_pkg::t_px r_grid [3][3];
    logic [3:0]   r_pend;
    logic         r_job_v, r_job_top, r_job_left;
    logic [CW-1:0] r_job_j;
    logic [RW-1:0] r_job_i;

    assign col2[0] = top_px;
    assign col2[1] = mid_px;
    assign col2[2] = r_p1_px;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= '0;
                r_win[r][1] <= '0;
            end
        end else if (p1_adv) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= col2[r];
            end
        end
    end

    logic [3:0]  sel;
    logic        slot_last, roff, coff, c_ready, c_adv;
    logic [2:0]  rm, cm;
    bb3_pkg::t_sum sum [3];
    bb3_pkg::t_cnt cnt;
    logic [RW-1:0] em_row;
    logic [CW-1:0] em_col;

    always_comb begin
        sel       = r_pend & (~r_pend + 4'd1);   // lowest pending slot
        slot_last = ((r_pend & ~sel) == 4'd0);
        roff      = sel[2] | sel[3];
        coff      = sel[1] | sel[3];
        rm        = {2'b11, !roff & r_job_top};
        cm        = {2'b11, !coff & r_job_left};
        for (int k = 0; k < 3; k++) begin
            sum[k] = '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    if (rm[r] & cm[c])
                        sum[k] = sum[k] + bb3_pkg::t_sum'(r_grid[r][c][8*k +: 8]);
                end
            end
        end
        if (rm[0] & cm[0])       cnt = bb3_pkg::CNT9;
        else if (rm[0] | cm[0])  cnt = bb3_pkg::CNT6;
        else                     cnt = bb3_pkg::CNT4;
        em_row = roff ? r_job_i : r_job_i - RW'(1);
        em_col = coff ? r_job_j : r_job_j - CW'(1);
    end

    assign c_adv     = r_job_v & c_ready;
    assign job_ready = !r_job_v | (c_ready & slot_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_v <= 1'b0;
            r_pend  <= '0;
        end else if (p1_adv & r_p1_emit) begin
            r_job_v <= 1'b1;
            r_pend  <= {r_p1_lc & r_p1_lr, r_p1_lr, r_p1_lc, 1'b1};
        end else if (c_adv) begin
            r_pend  <= r_pend & ~sel;
            r_job_v <= !slot_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p1_adv & r_p1_emit) begin
            for (int r = 0; r < 3; r++) begin
                r_grid[r][0] <= r_win[r][0];
                r_grid[r][1] <= r_win[r][1];
                r_grid[r][2] <= col2[r];
            end
            r_job_top  <= r_p1_top;
            r_job_left <= r_p1_left;
            r_job_i    <= r_p1_i;
            r_job_j    <= r_p1_j;
        end
    end

    // ---------------- stage C: sums ----------------
    logic          r_c_v, r_c_last, o_ready;
    bb3_pkg::t_sum r_c_sum [3];
    bb3_pkg::t_cnt r_c_cnt;
    logic [bb3_pkg::COORD_W-1:0] r_c_row, r_c_col;

    assign o_ready = !o_out_valid | i_out_ready;
    assign c_ready = !r_c_v | o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_v <= 1'b0;
        else if (c_ready) r_c_v <= r_job_v;
    end

    always_ff @(posedge i_clk) begin
        if (c_adv) begin
            r_c_sum  <= sum;
            r_c_cnt  <= cnt;
            r_c_row  <= bb3_pkg::COORD_W'(em_row);
            r_c_col  <= bb3_pkg::COORD_W'(em_col);
            r_c_last <= slot_last;
        end
    end

    // ---------------- stage O: rounding divide ----------------
    // (2s+n)/(2n) for n = 4, 6, 9
    function automatic logic [bb3_pkg::CH_W-1:0] round_mean(
        input bb3_pkg::t_sum s, input bb3_pkg::t_cnt n);
        logic [12:0] x6, x18;
        logic [28:0] p6;
        logic [30:0] p18;
        logic [12:0] x4;
        logic [bb3_pkg::CH_W-1:0] q;
        x4  = 13'(s) + 13'd2;
        x6  = 13'(s) + 13'd3;
        x18 = {s, 1'b0} + 13'd9;
        p6  = 29'(x6) * 29'(bb3_pkg::RECIP6);
        p18 = 31'(x18) * 31'(bb3_pkg::RECIP18);
        case (n)
            bb3_pkg::CNT4: q = x4[9:2];
            bb3_pkg::CNT6: q = p6[bb3_pkg::SHIFT6 +: bb3_pkg::CH_W];
            bb3_pkg::CNT9: q = p18[bb3_pkg::SHIFT18 +: bb3_pkg::CH_W];
            default:       q = '0;
        endcase
        return q;
    endfunction

    logic r_o_v;
    assign o_out_valid = r_o_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_v <= 1'b0;
        else if (o_ready) r_o_v <= r_c_v;
    end

    always_ff @(posedge i_clk) begin
        if (o_ready & r_c_v) begin
            o_out_red   <= round_mean(r_c_sum[0], r_c_cnt);
            o_out_green <= round_mean(r_c_sum[1], r_c_cnt);
            o_out_blue  <= round_mean(r_c_sum[2], r_c_cnt);
            o_out_row   <= r_c_row;
            o_out_col   <= r_c_col;
            o_run_last  <= r_c_last;
        end
    end

endmodule

// ===== hw/rtl/bb3_checker.sv =====
// ----------------------------------------------------------------------------
// Box blur port checker
// Watches the core's ports for result sequencing and handshake slips.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_edge_clipped_core_defines.svh"

module bb3_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [bb3_pkg::CH_W-1:0]      i_in_red,
    input logic [bb3_pkg::CH_W-1:0]      i_in_green,
    input logic [bb3_pkg::CH_W-1:0]      i_in_blue,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [bb3_pkg::COORD_W-1:0]   o_out_row,
    input logic [bb3_pkg::COORD_W-1:0]   o_out_col,
    input logic [bb3_pkg::CH_W-1:0]      o_out_red,
    input logic [bb3_pkg::CH_W-1:0]      o_out_green,
    input logic [bb3_pkg::CH_W-1:0]      o_out_blue,
    input logic                          o_run_last
);

    property p_out_hold;
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_row)
            && $stable(o_out_col) && $stable(o_out_red) && $stable(o_out_green)
            && $stable(o_out_blue) && $stable(o_run_last);
    endproperty

    property p_run_dense;
        o_out_valid && i_out_ready && !o_run_last |=> o_out_valid;
    endproperty

    property p_in_hold;
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_red)
            && $stable(i_in_green) && $stable(i_in_blue);
    endproperty

    // a stalled result beat holds
    `BB3_ASSERT(a_out_hold, i_clk, i_rst_n, p_out_hold, "result beat changed while stalled")

    // results of one pixel follow each other without gaps
    `BB3_ASSERT(a_run_dense, i_clk, i_rst_n, p_run_dense, "gap inside a pixel's result run")

    // a waiting pixel beat holds
    `BB3_ASSERT(a_in_hold, i_clk, i_rst_n, p_in_hold, "pixel beat changed while waiting")

    `BB3_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !o_out_valid, "result valid straight after reset")

endmodule

bind box_blur_3x3_edge_clipped_core bb3_checker u_bb3_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_red    (i_in_red),
    .i_in_green  (i_in_green),
    .i_in_blue   (i_in_blue),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_row   (o_out_row),
    .o_out_col   (o_out_col),
    .o_out_red   (o_out_red),
    .o_out_green (o_out_green),
    .o_out_blue  (o_out_blue),
    .o_run_last  (o_run_last)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Box blur core testbench
// Streams random and constant RGB frames of varied size through the 3x3 edge-clipped blur
// and checks every blurred pixel against an in-bench model of the window.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAXW = 1024;
    localparam int MAXH = 1024;

    typedef struct packed {
        logic [9:0] row;
        logic [9:0] col;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_blur_px;

    // expected blurred pixels and the blur model's own state
    class blur_board;
        t_blur_px pending[$];
        int unsigned fw, fh, row_n, col_n;
        logic [23:0] lines[2*MAXW];
        logic [23:0] win[3][2];
        int errors, checked;

        function void set_reg(logic [bb3_pkg::IDX_W-1:0] idx,
                              logic [bb3_pkg::CFG_W-1:0] val);
            if (idx == bb3_pkg::REG_FRAME_WIDTH) fw = val;
            else fh = val;
            row_n = 0;
            col_n = 0;
        endfunction

        function t_blur_px mean(logic [23:0] g[3][3], int ro, int co, bit top_ok,
                                bit left_ok, int r, int c);
            t_blur_px p;
            int s[3];
            int n;
            int gr, gc;
            s = '{0, 0, 0};
            n = 0;
            for (int dr = 0; dr < 3; dr++)
                for (int dc = 0; dc < 3; dc++) begin
                    gr = ro + dr;
                    gc = co + dc;
                    if (gr > 2 || gc > 2) continue;
                    if (gr == 0 && !top_ok) continue;
                    if (gc == 0 && !left_ok) continue;
                    for (int k = 0; k < 3; k++) s[k] += g[gr][gc][8*k +: 8];
                    n++;
                end
            p.row = 10'(r);
            p.col = 10'(c);
            p.red = 8'((2*s[0] + n) / (2*n));
            p.green = 8'((2*s[1] + n) / (2*n));
            p.blue = 8'((2*s[2] + n) / (2*n));
            p.last = 1'b0;
            return p;
        endfunction

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int unsigned w, h, i, j;
            logic [23:0] grid[3][3];
            bit lc, lr;
            w = fw < 2 ? 2 : (fw > MAXW ? MAXW : fw);
            h = fh < 2 ? 2 : (fh > MAXH ? MAXH : fh);
            i = row_n >= h ? h - 1 : row_n;
            j = col_n >= w ? w - 1 : col_n;
            for (int k = 0; k < 3; k++) begin
                grid[k][0] = win[k][0];
                grid[k][1] = win[k][1];
            end
            grid[0][2] = lines[MAXW + j];
            grid[1][2] = lines[j];
            grid[2][2] = {b, g, r};
            lc = (j == w - 1);
            lr = (i == h - 1);
            if (i >= 1 && j >= 1) begin
                pending.push_back(mean(grid, 0, 0, i >= 2, j >= 2, i - 1, j - 1));
                if (lc) pending.push_back(mean(grid, 0, 1, i >= 2, 1'b1, i - 1, j));
                if (lr) begin
                    pending.push_back(mean(grid, 1, 0, 1'b1, j >= 2, i, j - 1));
                    if (lc) pending.push_back(mean(grid, 1, 1, 1'b1, 1'b1, i, j));
                end
                pending[pending.size()-1].last = 1'b1;
            end
            lines[MAXW + j] = lines[j];
            lines[j] = {b, g, r};
            for (int k = 0; k < 3; k++) begin
                win[k][0] = grid[k][1];
                win[k][1] = grid[k][2];
            end
            if (lc) begin
                col_n = 0;
                row_n = lr ? 0 : i + 1;
            end else begin
                col_n = j + 1;
                row_n = i;
            end
        endfunction

        function void check_blur(t_blur_px got);
            t_blur_px exp_px;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            exp_px = pending.pop_front();
            if (got !== exp_px) begin
                errors++;
                if (errors <= 10) $display("mismatch: expected %p got %p", exp_px, got);
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [bb3_pkg::IDX_W-1:0] i_cfg_idx = bb3_pkg::REG_FRAME_WIDTH;
    logic [bb3_pkg::CFG_W-1:0] i_cfg_data = 0;
    logic i_in_valid = 0, i_out_ready = 0;
    logic [7:0] i_in_red = 0, i_in_green = 0, i_in_blue = 0;
    logic o_in_ready, o_out_valid, o_run_last;
    logic [9:0] o_out_row, o_out_col;
    logic [7:0] o_out_red, o_out_green, o_out_blue;

    blur_board board;
    int send_idle_pct, recv_stall_pct, hold_off;
    int pixels_sent, frames_done;

    always #5 i_clk = ~i_clk;

    box_blur_3x3_edge_clipped_core dut (.*);

    // receiver: random stalls, plus a counted long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_blur({o_out_row, o_out_col, o_out_red, o_out_green,
                              o_out_blue, o_run_last});
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_ready <= 0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one cycle of write enable, then write enable is dropped before the task returns
    task automatic write_reg(logic [bb3_pkg::IDX_W-1:0] idx,
                             logic [bb3_pkg::CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in_red <= r;
        i_in_green <= g;
        i_in_blue <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_pixel(r, g, b);
        pixels_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic run_frame(int w, int h, int mode);
        logic [7:0] v;
        write_reg(bb3_pkg::REG_FRAME_WIDTH, 11'(w));
        write_reg(bb3_pkg::REG_FRAME_HEIGHT, 11'(h));
        for (int n = 0; n < w * h; n++) begin
            v = mode == 1 ? 8'hff : (mode == 2 ? 8'h00 : 8'h0);
            if (mode == 0) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
            else send_pixel(v, v, v);
        end
        frames_done++;
    endtask

    initial begin
        int w, h;
        board = new();
        board.fw = bb3_pkg::WIDTH_RST;
        board.fh = bb3_pkg::HEIGHT_RST;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: smallest frame, saturated and zero channels, clamped sizes
        run_frame(2, 2, 1);
        drain();
        run_frame(2, 2, 2);
        drain();
        run_frame(3, 3, 0);
        drain();
        write_reg(bb3_pkg::REG_FRAME_HEIGHT, 11'd0);
        run_frame(0, 2, 0);       // width below range acts as 2, but w * h is 0, so no pixels are sent
        drain();
        // oversize width and height clamp; abandon after five pixels of row 0
        write_reg(bb3_pkg::REG_FRAME_WIDTH, 11'h7ff);
        write_reg(bb3_pkg::REG_FRAME_HEIGHT, 11'h7ff);
        for (int n = 0; n < 5; n++)
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        drain();

        // random frames across idling phases
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 65 : 31) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 65 : 31) : 0;
            if (ph == 0) hold_off = 60;
            for (int f = 0; f < 3; f++) begin
                w = $urandom_range(2, 7);
                h = $urandom_range(2, 5);
                run_frame(w, h, 0);
                drain();
            end
        end
        // one wider frame of two rows
        write_reg(bb3_pkg::REG_FRAME_HEIGHT, 11'd2);
        run_frame(60, 2, 0);
        drain();

        $display("Sent %0d pixels in %0d frames, %0d blurred pixels checked.",
                 pixels_sent, frames_done, board.checked);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bb3_pkg.sv
hw/rtl/box_blur_3x3_edge_clipped_core.sv
hw/rtl/bb3_checker.sv
tb/tb.sv
